// ===== src/phlrm_pkg.sv =====
// Package for the polar hit line residual mean core: widths, constants and CORDIC angle table.
// No dependencies.
`default_nettype none
package phlrm_pkg;
  localparam int MaxHitsDefault     = 1024;
  localparam int CordicStepsDefault = 16;
  localparam int TableLen           = 24;
  localparam int SumW               = 35;
  localparam int MeanW              = 24;
  localparam int CfgW               = 24;
  localparam int RadW               = 16;
  localparam int AngW               = 16;
  // x/y datapath: radius*gain (32 bits) plus CORDIC growth and sign
  localparam int XyW                = 36;
  localparam int ZW                 = 26;
  localparam logic [16:0] GainQ16   = 17'd39797;

  typedef enum logic [0:0] {
    REG_SLOPE     = 1'b0,
    REG_INTERCEPT = 1'b1
  } reg_index_t;

  // queue entry between the front and back parts
  typedef struct packed {
    logic [RadW-1:0] radius;
    logic [AngW-1:0] angle;
    logic            used;
    logic            last;
  } hit_t;

  function automatic logic [ZW-1:0] atan_entry(input logic [4:0] i);
    logic [ZW-1:0] v;
    unique case (i)
      5'd0:  v = 26'd2097152;
      5'd1:  v = 26'd1238021;
      5'd2:  v = 26'd654136;
      5'd3:  v = 26'd332050;
      5'd4:  v = 26'd166669;
      5'd5:  v = 26'd83416;
      5'd6:  v = 26'd41718;
      5'd7:  v = 26'd20860;
      5'd8:  v = 26'd10430;
      5'd9:  v = 26'd5215;
      5'd10: v = 26'd2608;
      5'd11: v = 26'd1304;
      5'd12: v = 26'd652;
      5'd13: v = 26'd326;
      5'd14: v = 26'd163;
      5'd15: v = 26'd81;
      5'd16: v = 26'd41;
      5'd17: v = 26'd20;
      5'd18: v = 26'd10;
      5'd19: v = 26'd5;
      5'd20: v = 26'd3;
      5'd21: v = 26'd1;
      5'd22: v = 26'd1;
      default: v = '0;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

// ===== src/phlrm_queue.sv =====
// Short hit queue between the input side and the residual engine.
// Depends on phlrm_pkg.
`default_nettype none
module phlrm_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_valid,
  output logic                  wr_ready,
  input  wire phlrm_pkg::hit_t  wr_data,
  output logic                  rd_valid,
  input  wire logic             rd_ready,
  output phlrm_pkg::hit_t       rd_data
);
  import phlrm_pkg::*;

  hit_t       mem [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] fill;
  logic       push;
  logic       pop;

  assign wr_ready = (fill != 3'd4);
  assign rd_valid = (fill != 3'd0);
  assign rd_data  = mem[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop)  rd_ptr <= rd_ptr + 2'd1;
      fill <= fill + {2'b0, push} - {2'b0, pop};
    end
  end
endmodule
`default_nettype wire

// ===== src/phlrm_engine.sv =====
// Residual engine: sequential CORDIC, line fit, accumulation and end-of-chain division.
// Depends on phlrm_pkg.
`default_nettype none
module phlrm_engine #(
  parameter int MAX_HITS     = phlrm_pkg::MaxHitsDefault,
  parameter int CORDIC_STEPS = phlrm_pkg::CordicStepsDefault
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire phlrm_pkg::hit_t             in_data,
  input  wire logic signed [phlrm_pkg::CfgW-1:0] slope,
  input  wire logic signed [phlrm_pkg::CfgW-1:0] intercept,
  output logic                             res_valid,
  input  wire logic                        res_ready,
  output logic [phlrm_pkg::MeanW-1:0]      res_mean,
  output logic                             res_none
);
  import phlrm_pkg::*;

  localparam int Steps = (CORDIC_STEPS > TableLen) ? TableLen : CORDIC_STEPS;
  localparam int CntW  = $clog2(MAX_HITS + 1);
  localparam int QW    = MeanW + 1;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_ROT   = 7'b0000010,
    S_MUL   = 7'b0000100,
    S_FIT   = 7'b0001000,
    S_ACC   = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t                   state;
  logic                     last;
  logic signed [XyW-1:0]    x;
  logic signed [XyW-1:0]    y;
  logic signed [ZW-1:0]     z;
  logic [4:0]               step;
  logic signed [XyW+CfgW-1:0] prod;
  logic signed [XyW+CfgW-16:0] diff;
  logic [SumW-1:0]          sum;
  logic [CntW-1:0]          count;
  logic [CntW-1:0]          rem;
  logic [SumW-1:0]          dvd;
  logic [QW-1:0]            quot;
  logic [5:0]               div_i;

  // start vector and angle fold
  logic signed [AngW:0]     z0;
  logic signed [AngW:0]     zf;
  logic                     neg0;
  logic signed [XyW-1:0]    x0;
  always_comb begin
    z0   = $signed({in_data.angle[AngW-1], in_data.angle});
    neg0 = 1'b0;
    zf   = z0;
    if (z0 > 17'sd16384) begin
      zf = z0 - 17'sd32768; neg0 = 1'b1;
    end else if (z0 < -17'sd16384) begin
      zf = z0 + 17'sd32768; neg0 = 1'b1;
    end
    x0 = $signed({4'b0, 32'(32'(in_data.radius) * 32'(GainQ16))});
    if (neg0) x0 = -x0;
  end

  // one CORDIC step
  logic signed [XyW-1:0] dx, dy;
  assign dx = y >>> step;
  assign dy = x >>> step;

  // residual rounding
  logic [XyW+CfgW-16:0] mag;
  logic [XyW+CfgW-32:0] resid;
  logic [SumW:0]        sum_add;
  assign mag     = diff[XyW+CfgW-16] ? -diff : diff;
  assign resid   = (XyW+CfgW-31)'((mag + (XyW+CfgW-15)'(32768)) >> 16);
  assign sum_add = {1'b0, sum} + (SumW+1)'(resid);

  // restoring division, one quotient bit a cycle; top quotient bit is sticky
  logic [CntW:0] part;
  logic [CntW:0] part_sub;
  logic          ge;
  logic [QW-1:0] quot_next;
  assign part      = {rem, dvd[SumW-1]};
  assign ge        = (part >= {1'b0, count});
  assign part_sub  = part - {1'b0, count};
  assign quot_next = {quot[QW-2:0], ge} | {quot[QW-1], {(QW-1){1'b0}}};

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sum   <= '0;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) begin
          last <= in_data.last;
          x    <= x0;
          y    <= '0;
          z    <= ZW'(zf) <<< 8;
          step <= '0;
          if (in_data.used && count < CntW'(MAX_HITS)) begin
            state <= S_ROT;
          end else if (in_data.last) begin
            state <= S_DIV;
            rem   <= '0;
            dvd   <= sum;
            quot  <= '0;
            div_i <= '0;
          end
        end
        S_ROT: begin
          if (!z[ZW-1]) begin
            x <= x - dx; y <= y + dy; z <= z - atan_entry(step);
          end else begin
            x <= x + dx; y <= y - dy; z <= z + atan_entry(step);
          end
          step <= step + 5'd1;
          if (step == 5'(Steps - 1)) state <= S_MUL;
        end
        S_MUL: begin
          prod  <= x * slope;
          state <= S_FIT;
        end
        S_FIT: begin
          diff  <= (XyW+CfgW-15)'(y) - (XyW+CfgW-15)'(prod >>> 16)
                   - ((XyW+CfgW-15)'(intercept) <<< 16);
          state <= S_ACC;
        end
        S_ACC: begin
          sum   <= sum_add[SumW] ? {SumW{1'b1}} : sum_add[SumW-1:0];
          count <= count + CntW'(1);
          if (last) begin
            state <= S_DIV;
            rem   <= '0;
            dvd   <= sum_add[SumW] ? {SumW{1'b1}} : sum_add[SumW-1:0];
            quot  <= '0;
            div_i <= '0;
          end else begin
            state <= S_IDLE;
          end
        end
        S_DIV: begin
          // long division of sum by count, quotient saturated
          if (count == '0) begin
            res_mean <= '0; res_none <= 1'b1; state <= S_OUT;
          end else begin
            rem   <= ge ? part_sub[CntW-1:0] : part[CntW-1:0];
            dvd   <= {dvd[SumW-2:0], 1'b0};
            quot  <= quot_next;
            div_i <= div_i + 6'd1;
            if (div_i == 6'(SumW - 1)) begin
              res_mean <= quot_next[QW-1] ? {MeanW{1'b1}} : quot_next[MeanW-1:0];
              res_none <= 1'b0;
              state    <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (res_ready) begin
            sum   <= '0;
            count <= '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== src/polar_hit_line_residual_mean_core.sv =====
// Top level of the polar hit line residual mean core: configuration, input front, queue, engine.
// Depends on phlrm_pkg, phlrm_queue and phlrm_engine.
`default_nettype none
// A hit is taken into a four-entry queue. The engine takes a hit from the queue
// only while idle, rotates it in its shared CORDIC rotation unit and then does
// the slope multiply, fit and accumulation in turn; an unused hit is passed over
// without rotation. The last hit of a chain adds a bit-serial division (skipped
// when no hit was used) before the result, which is held in an output register
// until taken; the engine takes the next hit the cycle after the result transfer.
module polar_hit_line_residual_mean_core #(
  parameter int MAX_HITS     = phlrm_pkg::MaxHitsDefault,
  parameter int CORDIC_STEPS = phlrm_pkg::CordicStepsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // hit_radius[15:0], hit_angle[31:16], hit_used[32]
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // mean_residual[23:0]
  output logic             m_axis_tuser,  // no_hits
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [23:0] cfg_data
);
  import phlrm_pkg::*;

  logic signed [CfgW-1:0] slope;
  logic signed [CfgW-1:0] intercept;
  hit_t                   hit_in;
  hit_t                   hit_q;
  logic                   q_valid;
  logic                   q_ready;

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      slope     <= '0;
      intercept <= '0;
    end else if (cfg_valid) begin
      unique case (reg_index_t'(cfg_index))
        REG_SLOPE:     slope     <= cfg_data;
        REG_INTERCEPT: intercept <= cfg_data;
        default: ;
      endcase
    end
  end

  // input front: unpack the hit
  assign hit_in.radius = s_axis_tdata[15:0];
  assign hit_in.angle  = s_axis_tdata[31:16];
  assign hit_in.used   = s_axis_tdata[32];
  assign hit_in.last   = s_axis_tlast;

  phlrm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (s_axis_tvalid),
    .wr_ready (s_axis_tready),
    .wr_data  (hit_in),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (hit_q)
  );

  phlrm_engine #(
    .MAX_HITS     (MAX_HITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .in_data   (hit_q),
    .slope     (slope),
    .intercept (intercept),
    .res_valid (m_axis_tvalid),
    .res_ready (m_axis_tready),
    .res_mean  (m_axis_tdata),
    .res_none  (m_axis_tuser)
  );
endmodule
`default_nettype wire
